// ===== hdl/bounded_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list engine
// Shared property shapes; each use expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BLE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bounded_list_engine: same-cycle check failed");

// Next-cycle implication, off during reset.
`define BLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bounded_list_engine: next-cycle check failed");

`endif

// ===== hdl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Codes, field widths and word layouts of the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int unsigned DEF_CAPACITY    = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Input word: mode, value, position
  localparam int unsigned IN_MODE_LSB  = 0;
  localparam int unsigned IN_VALUE_LSB = IN_MODE_LSB + MODE_W;
  localparam int unsigned IN_POS_LSB   = IN_VALUE_LSB + DATA_W;
  localparam int unsigned IN_BITS      = IN_POS_LSB + POS_W;
  localparam int unsigned S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output word: status, removed, count, front, back
  localparam int unsigned OUT_STATUS_LSB  = 0;
  localparam int unsigned OUT_REMOVED_LSB = OUT_STATUS_LSB + STATUS_W;
  localparam int unsigned OUT_COUNT_LSB   = OUT_REMOVED_LSB + DATA_W;
  localparam int unsigned OUT_FRONT_LSB   = OUT_COUNT_LSB + COUNT_W;
  localparam int unsigned OUT_BACK_LSB    = OUT_FRONT_LSB + DATA_W;
  localparam int unsigned OUT_BITS        = OUT_BACK_LSB + DATA_W;
  localparam int unsigned M_TDATA_W       = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_REVERSE   = 3'd6,
    MODE_NOP       = 3'd7
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_e;

endpackage

// ===== hdl/ble_ram.sv =====
// ----------------------------------------------------------------------------
// ble_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ble_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/bounded_list_engine.sv =====
// Sequence: reverse, no-op and errors go straight to reading the end cells; an
//   insert first shifts cells up, a delete first reads the removed cell and then
//   shifts cells down, one read and one write per shifted cell; an empty list skips the end-cell reads.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result is loaded into the output register, and that load waits while the
//   output stalls.
// Reset: count and orientation cleared at once; the cell RAM is not cleared.
// ----------------------------------------------------------------------------
// bounded_list_engine
// Bounded double-ended list held in a RAM, shifted cell by cell by a sequencer.
// ----------------------------------------------------------------------------
module bounded_list_engine #(
  parameter int unsigned CAPACITY    = ble_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_WIDTH = ble_pkg::DEF_VALUE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input word, LSB up: mode[2:0], value[34:3], position[41:35], zero pad
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ble_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // Result word, LSB up: status[1:0], removed_value[33:2], element_count[40:34],
  // front_value[72:41], back_value[104:73], zero pad
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ble_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);
  import ble_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  // Sequencer: insert shifts cells up from the tail, delete shifts them down
  // toward the hole; every operation ends by reading the two end cells of a non-empty list.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD0,
    S_DEL_GET,
    S_DEL_RD,
    S_DEL_WR,
    S_FR_RD,
    S_FR_GET,
    S_BK_GET,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic                    rev_q;
  logic [AW-1:0]           ptr_q;
  logic [AW-1:0]           idx_q;
  logic [VALUE_WIDTH-1:0]  val_q;
  logic [STATUS_W-1:0]     status_q;
  logic [VALUE_WIDTH-1:0]  removed_q;
  logic [VALUE_WIDTH-1:0]  first_q;
  logic [VALUE_WIDTH-1:0]  last_q;
  logic                    m_valid_q;
  logic [M_TDATA_W-1:0]    m_data_q;

  // Input word fields
  logic [MODE_W-1:0]       in_mode;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]        in_pos;

  assign in_mode  = s_axis_tdata_i[IN_MODE_LSB +: MODE_W];
  assign in_value = $signed(s_axis_tdata_i[IN_VALUE_LSB +: DATA_W]);
  assign in_pos   = s_axis_tdata_i[IN_POS_LSB +: POS_W];

  logic accept;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Decode at accept: fold end operations into positional ones, check range,
  // and map the logical position to a physical cell index.
  logic              is_ins;
  logic              is_del;
  logic [CMPW-1:0]   n_ext;
  logic [CMPW-1:0]   eff_pos;
  logic [CMPW-1:0]   phys_idx;
  logic [STATUS_W-1:0] acc_status;
  logic [AW-1:0]     acc_idx;

  always_comb begin
    n_ext   = CMPW'(count_q);
    eff_pos = CMPW'(in_pos);
    is_ins  = 1'b0;
    is_del  = 1'b0;
    case (mode_e'(in_mode))
      MODE_INS_FRONT: begin
        is_ins  = 1'b1;
        eff_pos = CMPW'(1);
      end
      MODE_INS_BACK: begin
        is_ins  = 1'b1;
        eff_pos = n_ext + 1'b1;
      end
      MODE_INS_POS: begin
        is_ins = 1'b1;
      end
      MODE_DEL_FRONT: begin
        is_del  = 1'b1;
        eff_pos = CMPW'(1);
      end
      MODE_DEL_BACK: begin
        is_del  = 1'b1;
        eff_pos = n_ext;
      end
      MODE_DEL_POS: begin
        is_del = 1'b1;
      end
      default: begin
      end
    endcase

    acc_status = ST_OK;
    if (is_ins) begin
      if (n_ext >= CMPW'(CAPACITY)) begin
        acc_status = ST_FULL;
      end else if (eff_pos == '0 || eff_pos > n_ext + 1'b1) begin
        acc_status = ST_BAD_POS;
      end
    end else if (is_del) begin
      if (n_ext == '0) begin
        acc_status = ST_EMPTY;
      end else if (eff_pos == '0 || eff_pos > n_ext) begin
        acc_status = ST_BAD_POS;
      end
    end

    if (!rev_q) begin
      phys_idx = eff_pos - 1'b1;
    end else if (is_ins) begin
      phys_idx = n_ext + 1'b1 - eff_pos;
    end else begin
      phys_idx = n_ext - eff_pos;
    end
    acc_idx = AW'(phys_idx);
  end

  // Cell RAM
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q - 1'b1;
      end
      S_INS_WR: begin
        ram_we = 1'b1;
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = val_q;
      end
      S_DEL_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      S_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q + 1'b1;
      end
      S_DEL_WR: begin
        ram_we = 1'b1;
      end
      S_FR_RD: begin
        ram_re    = (count_q != '0);
        ram_raddr = '0;
      end
      S_FR_GET: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(count_q - 1'b1);
      end
      default: begin
      end
    endcase
  end

  ble_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ble_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Result word; values leave sign-extended or truncated to 32 bits
  logic [M_TDATA_W-1:0] out_word;

  always_comb begin
    out_word = '0;
    out_word[OUT_STATUS_LSB +: STATUS_W] = status_q;
    out_word[OUT_REMOVED_LSB +: DATA_W]  = DATA_W'($signed(removed_q));
    out_word[OUT_COUNT_LSB +: COUNT_W]   = COUNT_W'(count_q);
    out_word[OUT_FRONT_LSB +: DATA_W]    = rev_q ? DATA_W'($signed(last_q))
                                                 : DATA_W'($signed(first_q));
    out_word[OUT_BACK_LSB +: DATA_W]     = rev_q ? DATA_W'($signed(first_q))
                                                 : DATA_W'($signed(last_q));
  end

  // Result goes into the output register once it is free or draining
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rev_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= out_word;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q  <= acc_status;
            removed_q <= '0;
            idx_q     <= acc_idx;
            val_q     <= VALUE_WIDTH'(in_value);
            ptr_q     <= AW'(count_q);
            if (mode_e'(in_mode) == MODE_REVERSE) begin
              rev_q <= ~rev_q;
            end
            if (acc_status == ST_OK && is_ins) begin
              state_q <= (CW'(acc_idx) < count_q) ? S_INS_RD : S_INS_PUT;
            end else if (acc_status == ST_OK && is_del) begin
              state_q <= S_DEL_RD0;
            end else begin
              state_q <= S_FR_RD;
            end
          end
        end
        S_INS_RD: begin
          state_q <= S_INS_WR;
        end
        S_INS_WR: begin
          ptr_q   <= ptr_q - 1'b1;
          state_q <= ((ptr_q - 1'b1) > idx_q) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: begin
          count_q <= count_q + 1'b1;
          state_q <= S_FR_RD;
        end
        S_DEL_RD0: begin
          state_q <= S_DEL_GET;
        end
        S_DEL_GET: begin
          removed_q <= ram_rdata;
          ptr_q     <= idx_q;
          count_q   <= count_q - 1'b1;
          state_q   <= (CW'(idx_q) + 1'b1 < count_q) ? S_DEL_RD : S_FR_RD;
        end
        S_DEL_RD: begin
          state_q <= S_DEL_WR;
        end
        S_DEL_WR: begin
          // count_q already holds the new count here
          ptr_q   <= ptr_q + 1'b1;
          state_q <= (CW'(ptr_q) + 2'd2 < count_q + 1'b1) ? S_DEL_RD : S_FR_RD;
        end
        S_FR_RD: begin
          if (count_q == '0) begin
            first_q <= '0;
            last_q  <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_FR_GET;
          end
        end
        S_FR_GET: begin
          first_q <= ram_rdata;
          state_q <= S_BK_GET;
        end
        S_BK_GET: begin
          last_q  <= ram_rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to drain
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hdl/ble_checker.sv =====
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks of the bounded list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_list_engine_assert.svh"

module ble_checker #(
  parameter int unsigned CAPACITY = ble_pkg::DEF_CAPACITY
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [ble_pkg::M_TDATA_W-1:0] m_tdata_i
);
  import ble_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [DATA_W-1:0]   front;
  logic [DATA_W-1:0]   back;
  logic                small_cap;

  assign status    = m_tdata_i[OUT_STATUS_LSB +: STATUS_W];
  assign count     = m_tdata_i[OUT_COUNT_LSB +: COUNT_W];
  assign front     = m_tdata_i[OUT_FRONT_LSB +: DATA_W];
  assign back      = m_tdata_i[OUT_BACK_LSB +: DATA_W];
  assign small_cap = (CAPACITY < (1 << COUNT_W));

  // one word in flight: busy right after an accept
  `BLE_ASSERT_NEXT(a_busy_after_accept, s_tvalid_i && s_tready_i, !s_tready_i)

  // a full report only comes with a full list
  `BLE_ASSERT_IMPLY(a_full_count, m_tvalid_i && status == ST_FULL && small_cap,
                    count == COUNT_W'(CAPACITY))

  // an empty list shows zero ends
  `BLE_ASSERT_IMPLY(a_empty_ends, m_tvalid_i && count == '0 && small_cap,
                    front == '0 && back == '0)

  // a stalled result holds
  `BLE_ASSERT_NEXT(a_out_hold, m_tvalid_i && !m_tready_i,
                   m_tvalid_i && $stable(m_tdata_i))

endmodule

bind bounded_list_engine ble_checker #(
  .CAPACITY (CAPACITY)
) u_ble_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
